// File: rtl/mfs_pkg.sv
package mfs_pkg;

  // default widths of the supervisor timers and the wheel angle
  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned ANGLE_WIDTH_DEF = 24;

  // configuration port geometry
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // payload widths fixed by the field definitions
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned TORQUE_W = 11;
  localparam int unsigned REASON_W = 2;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned MAG_W    = 10;

  // torque clamp limit
  localparam logic signed [TORQUE_W-1:0] TORQUE_LIMIT = 11'sd1000;

  // register reset values
  localparam logic [MS_W-1:0]  USB_TIMEOUT_RST = 16'd200;
  localparam logic [MS_W-1:0]  HID_TIMEOUT_RST = 16'd500;
  localparam logic [PCT_W-1:0] STUCK_PCT_RST   = 7'd80;
  localparam logic [MS_W-1:0]  STUCK_TIME_RST  = 16'd2000;
  localparam logic [MS_W-1:0]  STUCK_MOVE_RST  = 16'd512;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_USB_TIMEOUT    = 3'd0,
    REG_HID_TIMEOUT    = 3'd1,
    REG_STUCK_PCT      = 3'd2,
    REG_STUCK_TIME     = 3'd3,
    REG_STUCK_MOVE_MIN = 3'd4
  } cfg_index_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_UPDATE   = 2'd0,
    ACT_USB_KICK = 2'd1,
    ACT_HID_KICK = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE  = 2'd0,
    RSN_USB   = 2'd1,
    RSN_HID   = 2'd2,
    RSN_STUCK = 2'd3
  } reason_t;

  // current configuration handed to the checker
  typedef struct packed {
    logic [MS_W-1:0]  usb_limit_ms;
    logic [MS_W-1:0]  hid_limit_ms;
    logic [PCT_W-1:0] stall_torque_pct;
    logic [MS_W-1:0]  stall_limit_ms;
    logic [MS_W-1:0]  stuck_move_min;
  } cfg_t;

  // result of one processed word
  typedef struct packed {
    logic    stop_motor;
    logic    fault_latched;
    reason_t fault_reason;
  } result_t;

endpackage

// File: rtl/mfs_in_if.sv
interface mfs_in_if #(
  parameter int unsigned ANGLE_WIDTH = mfs_pkg::ANGLE_WIDTH_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic [mfs_pkg::ACTION_W-1:0]           action;
  logic signed [mfs_pkg::TORQUE_W-1:0]    torque_cmd;
  logic signed [ANGLE_WIDTH-1:0]          wheel_angle;

  modport source (output valid, action, torque_cmd, wheel_angle, input ready);
  modport sink   (input valid, action, torque_cmd, wheel_angle, output ready);
endinterface

// File: rtl/mfs_out_if.sv
interface mfs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         stop_motor;
  logic                         fault_latched;
  logic [mfs_pkg::REASON_W-1:0] fault_reason;

  modport source (output valid, stop_motor, fault_latched, fault_reason, input ready);
  modport sink   (input valid, stop_motor, fault_latched, fault_reason, output ready);
endinterface

// File: rtl/mfs_cfg_regs.sv
module mfs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output mfs_pkg::cfg_t                    cfg
);
  import mfs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register file write decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_USB_TIMEOUT:    cfg_nxt.usb_limit_ms     = cfg_wdata[MS_W-1:0];
        REG_HID_TIMEOUT:    cfg_nxt.hid_limit_ms     = cfg_wdata[MS_W-1:0];
        REG_STUCK_PCT:      cfg_nxt.stall_torque_pct = cfg_wdata[PCT_W-1:0];
        REG_STUCK_TIME:     cfg_nxt.stall_limit_ms   = cfg_wdata[MS_W-1:0];
        REG_STUCK_MOVE_MIN: cfg_nxt.stuck_move_min   = cfg_wdata[MS_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.usb_limit_ms     <= USB_TIMEOUT_RST;
      cfg_r.hid_limit_ms     <= HID_TIMEOUT_RST;
      cfg_r.stall_torque_pct <= STUCK_PCT_RST;
      cfg_r.stall_limit_ms   <= STUCK_TIME_RST;
      cfg_r.stuck_move_min   <= STUCK_MOVE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/mfs_core.sv
module mfs_core #(
  parameter int unsigned TIMER_WIDTH = mfs_pkg::TIMER_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = mfs_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  logic [mfs_pkg::ACTION_W-1:0]         action,
  input  logic signed [mfs_pkg::TORQUE_W-1:0]  torque_cmd,
  input  logic signed [ANGLE_WIDTH-1:0]        wheel_angle,
  input  mfs_pkg::cfg_t                        cfg,
  output mfs_pkg::result_t                     result
);
  import mfs_pkg::*;

  // compare widths wide enough for both the counters and the registers
  localparam int unsigned CMP_W  = (TIMER_WIDTH > MS_W) ? TIMER_WIDTH : MS_W;
  localparam int unsigned DIFF_W = ANGLE_WIDTH + 1;
  localparam int unsigned MV_W   = (DIFF_W > MS_W) ? DIFF_W : MS_W;

  logic [TIMER_WIDTH-1:0] usb_elapsed_r, usb_elapsed_nxt;
  logic [TIMER_WIDTH-1:0] hid_elapsed_r, hid_elapsed_nxt;
  logic [TIMER_WIDTH-1:0] stuck_elapsed_r, stuck_elapsed_nxt;
  logic                   stuck_running_r, stuck_running_nxt;
  logic [ANGLE_WIDTH-1:0] ref_angle_r, ref_angle_nxt;
  logic                   latched_r, latched_nxt;
  reason_t                reason_r, reason_nxt;
  logic                   usb_seen_r, usb_seen_nxt;
  logic                   hid_seen_r, hid_seen_nxt;
  logic                   stop;

  logic [TIMER_WIDTH-1:0] usb_inc, hid_inc, stuck_inc;
  logic signed [TORQUE_W-1:0] torque_clamped;
  logic [MAG_W-1:0]           torque_mag;
  logic [TORQUE_W-1:0]        pct_x10;
  logic                       torque_high;
  logic signed [DIFF_W-1:0]   angle_diff;
  logic [DIFF_W-1:0]          angle_moved;
  logic                       wheel_moved;
  logic                       usb_expired, hid_expired, stuck_expired;

  // saturating increments
  assign usb_inc   = (&usb_elapsed_r)   ? usb_elapsed_r   : usb_elapsed_r + 1'b1;
  assign hid_inc   = (&hid_elapsed_r)   ? hid_elapsed_r   : hid_elapsed_r + 1'b1;
  assign stuck_inc = (&stuck_elapsed_r) ? stuck_elapsed_r : stuck_elapsed_r + 1'b1;

  // timeout compares on the advanced counters
  assign usb_expired = CMP_W'(usb_inc) > CMP_W'(cfg.usb_limit_ms);
  assign hid_expired = CMP_W'(hid_inc) > CMP_W'(cfg.hid_limit_ms);
  assign stuck_expired = CMP_W'(stuck_running_r ? stuck_inc : stuck_elapsed_r)
                         >= CMP_W'(cfg.stall_limit_ms);

  // torque clamp, magnitude and percent threshold as mag >= 10 * pct
  always_comb begin
    if (torque_cmd > TORQUE_LIMIT) begin
      torque_clamped = TORQUE_LIMIT;
    end else if (torque_cmd < -TORQUE_LIMIT) begin
      torque_clamped = -TORQUE_LIMIT;
    end else begin
      torque_clamped = torque_cmd;
    end
  end

  always_comb begin
    logic [TORQUE_W-1:0] abs_t;
    abs_t = torque_clamped[TORQUE_W-1] ? TORQUE_W'(-torque_clamped)
                                       : TORQUE_W'(torque_clamped);
    torque_mag = abs_t[MAG_W-1:0];
  end

  assign pct_x10     = (TORQUE_W'(cfg.stall_torque_pct) << 3)
                     + (TORQUE_W'(cfg.stall_torque_pct) << 1);
  assign torque_high = TORQUE_W'(torque_mag) >= pct_x10;

  // wheel movement against the reference angle
  assign angle_diff  = $signed({wheel_angle[ANGLE_WIDTH-1], wheel_angle})
                     - $signed({ref_angle_r[ANGLE_WIDTH-1], ref_angle_r});
  assign angle_moved = angle_diff[DIFF_W-1] ? DIFF_W'(-angle_diff) : DIFF_W'(angle_diff);
  assign wheel_moved = MV_W'(angle_moved) >= MV_W'(cfg.stuck_move_min);

  // next state for one word
  always_comb begin
    usb_elapsed_nxt   = usb_elapsed_r;
    hid_elapsed_nxt   = hid_elapsed_r;
    stuck_elapsed_nxt = stuck_elapsed_r;
    stuck_running_nxt = stuck_running_r;
    ref_angle_nxt     = ref_angle_r;
    latched_nxt       = latched_r;
    reason_nxt        = reason_r;
    usb_seen_nxt      = usb_seen_r;
    hid_seen_nxt      = hid_seen_r;
    stop              = 1'b0;
    unique case (action_t'(action))
      ACT_UPDATE: begin
        usb_elapsed_nxt = usb_inc;
        hid_elapsed_nxt = hid_inc;
        if (stuck_running_r) begin
          stuck_elapsed_nxt = stuck_inc;
        end
        if (!latched_r) begin
          priority if (usb_seen_r && usb_expired) begin
            latched_nxt = 1'b1;
            reason_nxt  = RSN_USB;
            stop        = 1'b1;
          end else if (hid_seen_r && hid_expired) begin
            latched_nxt = 1'b1;
            reason_nxt  = RSN_HID;
            stop        = 1'b1;
          end else if (torque_high) begin
            priority if (!stuck_running_r) begin
              stuck_running_nxt = 1'b1;
              stuck_elapsed_nxt = '0;
              ref_angle_nxt     = wheel_angle;
            end else if (wheel_moved) begin
              stuck_running_nxt = 1'b0;
              stuck_elapsed_nxt = '0;
              ref_angle_nxt     = wheel_angle;
            end else if (stuck_expired) begin
              latched_nxt = 1'b1;
              reason_nxt  = RSN_STUCK;
              stop        = 1'b1;
            end else begin
              stuck_running_nxt = 1'b1;
            end
          end else begin
            stuck_running_nxt = 1'b0;
            stuck_elapsed_nxt = '0;
          end
        end
      end
      ACT_USB_KICK: begin
        usb_elapsed_nxt = '0;
        usb_seen_nxt    = 1'b1;
        if (latched_r && (reason_r == RSN_USB)) begin
          latched_nxt = 1'b0;
          reason_nxt  = RSN_NONE;
        end
      end
      ACT_HID_KICK: begin
        hid_elapsed_nxt = '0;
        hid_seen_nxt    = 1'b1;
      end
      ACT_CLEAR: begin
        latched_nxt       = 1'b0;
        reason_nxt        = RSN_NONE;
        stuck_running_nxt = 1'b0;
        stuck_elapsed_nxt = '0;
        usb_elapsed_nxt   = '0;
        hid_elapsed_nxt   = '0;
      end
      default: begin
        stop = 1'b0;
      end
    endcase
  end

  // supervisor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usb_elapsed_r   <= '0;
      hid_elapsed_r   <= '0;
      stuck_elapsed_r <= '0;
      stuck_running_r <= 1'b0;
      ref_angle_r     <= '0;
      latched_r       <= 1'b0;
      reason_r        <= RSN_NONE;
      usb_seen_r      <= 1'b0;
      hid_seen_r      <= 1'b0;
    end else if (fire) begin
      usb_elapsed_r   <= usb_elapsed_nxt;
      hid_elapsed_r   <= hid_elapsed_nxt;
      stuck_elapsed_r <= stuck_elapsed_nxt;
      stuck_running_r <= stuck_running_nxt;
      ref_angle_r     <= ref_angle_nxt;
      latched_r       <= latched_nxt;
      reason_r        <= reason_nxt;
      usb_seen_r      <= usb_seen_nxt;
      hid_seen_r      <= hid_seen_nxt;
    end
  end

  assign result.stop_motor    = stop;
  assign result.fault_latched = latched_nxt;
  assign result.fault_reason  = reason_nxt;

endmodule

// File: rtl/motor_failsafe_supervisor_top.sv
// datapath: an accepted word waits in the input register until the result
//   register is free, then its result is registered there and driven on out_if
// throughput: one word per cycle while out_if.ready keeps the result register
//   free, set by the combinational checker between the two registers
// reset: synchronous active-low rst_n clears all timers, flags, the latch and
//   both pipeline valids and loads the register defaults
module motor_failsafe_supervisor_top #(
  parameter int unsigned TIMER_WIDTH = mfs_pkg::TIMER_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = mfs_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mfs_in_if.sink                           in_if,
  mfs_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [mfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mfs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mfs_pkg::*;

  cfg_t    cfg;
  result_t result;

  logic                          in_valid_r;
  logic [ACTION_W-1:0]           action_r;
  logic signed [TORQUE_W-1:0]    torque_r;
  logic signed [ANGLE_WIDTH-1:0] angle_r;
  logic                          out_valid_r;
  result_t                       out_word_r;
  logic                          out_free;
  logic                          fire;

  // the result register frees up when empty or being drained
  assign out_free    = !out_valid_r || out_if.ready;
  assign fire        = in_valid_r && out_free;
  assign in_if.ready = !in_valid_r || out_free;

  mfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mfs_core #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .action      (action_r),
    .torque_cmd  (torque_r),
    .wheel_angle (angle_r),
    .cfg         (cfg),
    .result      (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      action_r <= in_if.action;
      torque_r <= in_if.torque_cmd;
      angle_r  <= in_if.wheel_angle;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= result;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.stop_motor    = out_word_r.stop_motor;
  assign out_if.fault_latched = out_word_r.fault_latched;
  assign out_if.fault_reason  = out_word_r.fault_reason;

endmodule
